[rtl/hrhp_pkg.sv]
`timescale 1ns / 1ps
// Package: shared types and constants for the HTTP request head parser.
package hrhp_pkg;

  // Widths of the saturating version and length counters.
  localparam int LENGTH_BITS  = 32;
  localparam int VERSION_BITS = 16;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_request;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              parse_status;
    logic [2:0]              byte_class;
    logic                    header_begins;
    logic [7:0]              byte_out;
    logic [VERSION_BITS-1:0] major_version;
    logic [VERSION_BITS-1:0] minor_version;
    logic [LENGTH_BITS-1:0]  body_length;
    logic                    body_expected;
  } out_item_t;

  typedef enum logic [4:0] {
    PH_METHOD_START, PH_METHOD, PH_URI, PH_VER_H, PH_VER_T1, PH_VER_T2,
    PH_VER_P, PH_VER_SLASH, PH_MAJOR_START, PH_MAJOR, PH_MINOR_START,
    PH_MINOR, PH_NL1, PH_LINE_START, PH_LWS, PH_NAME, PH_SPACE, PH_VALUE,
    PH_NL2, PH_NL3, PH_BODY
  } phase_t;

  localparam logic [1:0] ST_INCOMPLETE = 2'd0;
  localparam logic [1:0] ST_COMPLETE   = 2'd1;
  localparam logic [1:0] ST_MALFORMED  = 2'd2;

  localparam logic [2:0] CL_DELIM  = 3'd0;
  localparam logic [2:0] CL_METHOD = 3'd1;
  localparam logic [2:0] CL_URI    = 3'd2;
  localparam logic [2:0] CL_NAME   = 3'd3;
  localparam logic [2:0] CL_VALUE  = 3'd4;
  localparam logic [2:0] CL_BODY   = 3'd5;

  localparam int unsigned NAME_LEN = 14;

  // Characters of the header name that carries the body length.
  function automatic logic [7:0] length_name(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0: c = "C";  4'd1: c = "o";  4'd2: c = "n";  4'd3: c = "t";
      4'd4: c = "e";  4'd5: c = "n";  4'd6: c = "t";  4'd7: c = "-";
      4'd8: c = "L";  4'd9: c = "e";  4'd10: c = "n"; 4'd11: c = "g";
      4'd12: c = "t"; 4'd13: c = "h";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_decimal(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_ctl(input logic [7:0] b);
    return (b <= 8'd31) || (b == 8'd127);
  endfunction

  function automatic logic is_token(input logic [7:0] b);
    logic r;
    r = !(b[7] || is_ctl(b));
    unique case (b)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?",
      "=", "{", "}", " ", 8'h09: r = 1'b0;
      default: ;
    endcase
    return r;
  endfunction

  // Small record handed from the front stage to the parser.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start;
    logic       digit;
    logic       ctl;
    logic       token;
  } cls_item_t;

endpackage

[rtl/hrhp_front.sv]
`timescale 1ns / 1ps
// Front stage: accepts input items, classifies each byte and registers it.
module hrhp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  hrhp_pkg::in_item_t  in_data,
  output logic                cls_valid,
  input  logic                cls_take,
  output hrhp_pkg::cls_item_t cls_data
);

  logic accept;

  // The stage holds one item; it refills in the cycle it empties.
  assign in_stall = cls_valid && !cls_take;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cls_valid <= 1'b0;
    end else if (accept) begin
      cls_valid <= 1'b1;
    end else if (cls_take) begin
      cls_valid <= 1'b0;
    end
  end

  // Character classes are worked out once, here.
  always_ff @(posedge clk) begin
    if (accept) begin
      cls_data.data_byte <= in_data.data_byte;
      cls_data.start     <= in_data.start_of_request;
      cls_data.digit     <= hrhp_pkg::is_decimal(in_data.data_byte);
      cls_data.ctl       <= hrhp_pkg::is_ctl(in_data.data_byte);
      cls_data.token     <= hrhp_pkg::is_token(in_data.data_byte);
    end
  end

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    cls_valid && !cls_take |=> cls_valid && $stable(cls_data))
    else $error("front item changed while held");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> cls_valid)
    else $error("front stalled while empty");
  a_take: assert property (@(posedge clk) disable iff (rst)
    cls_take |-> cls_valid)
    else $error("item taken from empty front");
`endif

endmodule

[rtl/hrhp_back.sv]
`timescale 1ns / 1ps
// Back stage: parser state machine with a registered output item.
module hrhp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cls_valid,
  output logic                cls_take,
  input  hrhp_pkg::cls_item_t cls_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hrhp_pkg::out_item_t out_data
);

  localparam int LENGTH_BITS  = hrhp_pkg::LENGTH_BITS;
  localparam int VERSION_BITS = hrhp_pkg::VERSION_BITS;

  localparam logic [VERSION_BITS-1:0] VMAX = '1;
  localparam logic [LENGTH_BITS-1:0]  LMAX = '1;

  hrhp_pkg::phase_t        phase, phase_next;
  logic [1:0]              status, status_next;
  logic [VERSION_BITS-1:0] ver_hi, ver_hi_next, ver_lo, ver_lo_next;
  logic                    seen_hdr, seen_hdr_next;
  logic [3:0]              midx, midx_next;
  logic                    mok, mok_next;
  logic                    is_len, is_len_next;
  logic [LENGTH_BITS-1:0]  acc, acc_next;
  logic                    dend, dend_next;
  logic                    exp_body, exp_body_next;
  logic [LENGTH_BITS-1:0]  bsize, bsize_next;
  logic [LENGTH_BITS-1:0]  brecv, brecv_next;
  logic [2:0]              cls;
  logic                    hb;
  logic [7:0]              b;
  logic [3:0]              dig;
  logic                    go;

  // Effective state: a start flag clears everything before the byte.
  hrhp_pkg::phase_t        e_phase;
  logic [1:0]              e_status;
  logic [VERSION_BITS-1:0] e_hi, e_lo;
  logic                    e_seen, e_mok, e_len, e_dend, e_exp;
  logic [3:0]              e_midx;
  logic [LENGTH_BITS-1:0]  e_acc, e_bsize, e_brecv;

  // Take the next item whenever the output register is free or leaving.
  assign cls_take = cls_valid && (!out_valid || !out_stall);
  assign go       = cls_take;
  assign b        = cls_data.data_byte;
  assign dig      = b[3:0] - 4'd0;

  // Saturating times-ten accumulate.
  function automatic logic [VERSION_BITS-1:0] ver_step(input logic [VERSION_BITS-1:0] a,
                                                       input logic [3:0] d);
    logic [VERSION_BITS+4:0] t;
    t = {a, 3'b000} + {3'b000, a, 1'b0} + (VERSION_BITS+5)'(d);
    return (t > (VERSION_BITS+5)'(VMAX)) ? VMAX : t[VERSION_BITS-1:0];
  endfunction

  function automatic logic [LENGTH_BITS-1:0] len_step(input logic [LENGTH_BITS-1:0] a,
                                                      input logic [3:0] d);
    logic [LENGTH_BITS+4:0] t;
    t = {a, 3'b000} + {3'b000, a, 1'b0} + (LENGTH_BITS+5)'(d);
    return (t > (LENGTH_BITS+5)'(LMAX)) ? LMAX : t[LENGTH_BITS-1:0];
  endfunction

  always_comb begin
    if (cls_data.start) begin
      e_phase = hrhp_pkg::PH_METHOD_START; e_status = hrhp_pkg::ST_INCOMPLETE;
      e_hi = '0; e_lo = '0; e_seen = 1'b0; e_midx = 4'd0; e_mok = 1'b1;
      e_len = 1'b0; e_acc = '0; e_dend = 1'b0; e_exp = 1'b0;
      e_bsize = '0; e_brecv = '0;
    end else begin
      e_phase = phase; e_status = status; e_hi = ver_hi; e_lo = ver_lo;
      e_seen = seen_hdr; e_midx = midx; e_mok = mok; e_len = is_len;
      e_acc = acc; e_dend = dend; e_exp = exp_body; e_bsize = bsize;
      e_brecv = brecv;
    end
  end

  // Next state and the byte's class.
  always_comb begin
    logic bad, good, vb, mb;
    bad = 1'b0; good = 1'b0; vb = 1'b0; mb = 1'b0;
    phase_next = e_phase; status_next = e_status; ver_hi_next = e_hi;
    ver_lo_next = e_lo; seen_hdr_next = e_seen; midx_next = e_midx;
    mok_next = e_mok; is_len_next = e_len; acc_next = e_acc;
    dend_next = e_dend; exp_body_next = e_exp; bsize_next = e_bsize;
    brecv_next = e_brecv; cls = hrhp_pkg::CL_DELIM; hb = 1'b0;
    if (e_status == hrhp_pkg::ST_INCOMPLETE) begin
      unique case (e_phase)
        hrhp_pkg::PH_METHOD_START:
          if (cls_data.token) begin
            phase_next = hrhp_pkg::PH_METHOD; cls = hrhp_pkg::CL_METHOD;
          end else bad = 1'b1;
        hrhp_pkg::PH_METHOD:
          if (b == " ") phase_next = hrhp_pkg::PH_URI;
          else if (cls_data.token) cls = hrhp_pkg::CL_METHOD;
          else bad = 1'b1;
        hrhp_pkg::PH_URI:
          if (b == " ") phase_next = hrhp_pkg::PH_VER_H;
          else if (cls_data.ctl) bad = 1'b1;
          else cls = hrhp_pkg::CL_URI;
        hrhp_pkg::PH_VER_H:
          if (b == "H") phase_next = hrhp_pkg::PH_VER_T1; else bad = 1'b1;
        hrhp_pkg::PH_VER_T1:
          if (b == "T") phase_next = hrhp_pkg::PH_VER_T2; else bad = 1'b1;
        hrhp_pkg::PH_VER_T2:
          if (b == "T") phase_next = hrhp_pkg::PH_VER_P; else bad = 1'b1;
        hrhp_pkg::PH_VER_P:
          if (b == "P") phase_next = hrhp_pkg::PH_VER_SLASH; else bad = 1'b1;
        hrhp_pkg::PH_VER_SLASH:
          if (b == "/") begin
            ver_hi_next = '0; ver_lo_next = '0;
            phase_next = hrhp_pkg::PH_MAJOR_START;
          end else bad = 1'b1;
        hrhp_pkg::PH_MAJOR_START, hrhp_pkg::PH_MAJOR:
          if (cls_data.digit) begin
            ver_hi_next = ver_step(e_hi, dig); phase_next = hrhp_pkg::PH_MAJOR;
          end else if (b == "." && e_phase == hrhp_pkg::PH_MAJOR)
            phase_next = hrhp_pkg::PH_MINOR_START;
          else bad = 1'b1;
        hrhp_pkg::PH_MINOR_START, hrhp_pkg::PH_MINOR:
          if (cls_data.digit) begin
            ver_lo_next = ver_step(e_lo, dig); phase_next = hrhp_pkg::PH_MINOR;
          end else if (b == 8'h0d && e_phase == hrhp_pkg::PH_MINOR)
            phase_next = hrhp_pkg::PH_NL1;
          else bad = 1'b1;
        hrhp_pkg::PH_NL1:
          if (b == 8'h0a) phase_next = hrhp_pkg::PH_LINE_START; else bad = 1'b1;
        hrhp_pkg::PH_LINE_START:
          if (b == 8'h0d) phase_next = hrhp_pkg::PH_NL3;
          else if (e_seen && (b == " " || b == 8'h09)) phase_next = hrhp_pkg::PH_LWS;
          else if (cls_data.token) begin
            seen_hdr_next = 1'b1; is_len_next = 1'b0; acc_next = '0;
            dend_next = 1'b0;
            if (b == hrhp_pkg::length_name(4'd0)) begin
              midx_next = 4'd1; mok_next = 1'b1;
            end else begin
              midx_next = 4'd0; mok_next = 1'b0;
            end
            phase_next = hrhp_pkg::PH_NAME; cls = hrhp_pkg::CL_NAME; hb = 1'b1;
          end else bad = 1'b1;
        hrhp_pkg::PH_LWS:
          if (b == 8'h0d) phase_next = hrhp_pkg::PH_NL2;
          else if (b == " " || b == 8'h09) ;
          else if (cls_data.ctl) bad = 1'b1;
          else begin
            phase_next = hrhp_pkg::PH_VALUE; vb = 1'b1; cls = hrhp_pkg::CL_VALUE;
          end
        hrhp_pkg::PH_NAME:
          if (b == ":") begin
            is_len_next = e_mok && (e_midx == 4'(hrhp_pkg::NAME_LEN));
            if (e_mok && (e_midx == 4'(hrhp_pkg::NAME_LEN))) exp_body_next = 1'b1;
            phase_next = hrhp_pkg::PH_SPACE;
          end else if (cls_data.token) begin
            mb = 1'b1; cls = hrhp_pkg::CL_NAME;
          end else bad = 1'b1;
        hrhp_pkg::PH_SPACE:
          if (b == " ") phase_next = hrhp_pkg::PH_VALUE; else bad = 1'b1;
        hrhp_pkg::PH_VALUE:
          if (b == 8'h0d) begin
            if (e_len) bsize_next = e_acc;
            phase_next = hrhp_pkg::PH_NL2;
          end else if (cls_data.ctl) bad = 1'b1;
          else begin
            vb = 1'b1; cls = hrhp_pkg::CL_VALUE;
          end
        hrhp_pkg::PH_NL2:
          if (b == 8'h0a) phase_next = hrhp_pkg::PH_LINE_START; else bad = 1'b1;
        hrhp_pkg::PH_NL3:
          if (b == 8'h0a) begin
            if (e_exp && e_bsize != '0) begin
              brecv_next = '0; phase_next = hrhp_pkg::PH_BODY;
            end else good = 1'b1;
          end else bad = 1'b1;
        hrhp_pkg::PH_BODY: begin
          cls = hrhp_pkg::CL_BODY;
          brecv_next = e_brecv + 1'b1;
          if (e_brecv + 1'b1 >= e_bsize) good = 1'b1;
        end
        default: bad = 1'b1;
      endcase
      // Name matching against the length header.
      if (mb) begin
        if (e_mok && e_midx < 4'(hrhp_pkg::NAME_LEN) && b == hrhp_pkg::length_name(e_midx))
          midx_next = e_midx + 4'd1;
        else mok_next = 1'b0;
      end
      // Leading digits of the length value.
      if (vb && e_len && !e_dend) begin
        if (cls_data.digit) acc_next = len_step(e_acc, dig);
        else dend_next = 1'b1;
      end
      if (bad) begin
        status_next = hrhp_pkg::ST_MALFORMED; cls = hrhp_pkg::CL_DELIM; hb = 1'b0;
      end else if (good) status_next = hrhp_pkg::ST_COMPLETE;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= hrhp_pkg::PH_METHOD_START; status <= hrhp_pkg::ST_INCOMPLETE;
      ver_hi <= '0; ver_lo <= '0; seen_hdr <= 1'b0; midx <= 4'd0; mok <= 1'b1;
      is_len <= 1'b0; acc <= '0; dend <= 1'b0; exp_body <= 1'b0;
      bsize <= '0; brecv <= '0;
    end else if (go) begin
      phase <= phase_next; status <= status_next; ver_hi <= ver_hi_next;
      ver_lo <= ver_lo_next; seen_hdr <= seen_hdr_next; midx <= midx_next;
      mok <= mok_next; is_len <= is_len_next; acc <= acc_next;
      dend <= dend_next; exp_body <= exp_body_next; bsize <= bsize_next;
      brecv <= brecv_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_data.parse_status  <= status_next;
      out_data.byte_class    <= cls;
      out_data.header_begins <= hb;
      out_data.byte_out      <= b;
      out_data.major_version <= ver_hi_next;
      out_data.minor_version <= ver_lo_next;
      out_data.body_length   <= bsize_next;
      out_data.body_expected <= exp_body_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_status: assert property (@(posedge clk) disable iff (rst)
    status != 2'd3)
    else $error("illegal status code");
  a_final_hold: assert property (@(posedge clk) disable iff (rst)
    go && !cls_data.start && status != hrhp_pkg::ST_INCOMPLETE |=> $stable(status))
    else $error("final status changed without start");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");
  a_hb: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.header_begins |-> out_data.byte_class == hrhp_pkg::CL_NAME)
    else $error("header start outside a name");
`endif

endmodule

[rtl/http_request_head_parser.sv]
`timescale 1ns / 1ps
// Top level of the HTTP/1.x request head parser.
//
// The block takes one byte of a request stream per input item and returns
// one result item per byte: the running status, the class of the byte, a
// header-start mark, the byte itself, the version numbers, the committed
// Content-Length value and whether such a header was seen.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low. A front register classifies the byte, the back stage runs
// the parser state machine and holds the result in an output register.
// The result item passes through the front register and then the output
// register, and one item is taken every cycle while the receiver does not
// stall; the parser step in the back stage is combinational and takes an
// item whenever the output register is free or being taken.
// When the receiver stalls, the output register holds its item, the front
// register fills, and then the input channel is stalled.
// Synchronous reset empties both registers and returns the parser to the
// start of a method; start_of_request does the same before its byte.
module http_request_head_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  hrhp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hrhp_pkg::out_item_t out_data
);

  logic                cls_valid;
  logic                cls_take;
  hrhp_pkg::cls_item_t cls_data;

  hrhp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cls_valid (cls_valid),
    .cls_take  (cls_take),
    .cls_data  (cls_data)
  );

  hrhp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cls_valid (cls_valid),
    .cls_take  (cls_take),
    .cls_data  (cls_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[sim/tb_http_request_head_parser.sv]
`timescale 1ns / 1ps
// Testbench for the HTTP request head parser: predicts every result item and checks it.
module tb_http_request_head_parser;

  localparam logic [15:0] VER_MAX = 16'hFFFF;
  localparam logic [31:0] LEN_MAX = 32'hFFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  hrhp_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  hrhp_pkg::out_item_t out_data;

  http_request_head_parser dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  always #10 clk = ~clk;

  // Parser state kept by the predictor.
  hrhp_pkg::phase_t p_phase;
  logic [1:0]  p_status;
  logic [15:0] p_major, p_minor;
  logic        p_seen_hdr, p_still, p_is_len, p_ended, p_exp_body;
  logic [3:0]  p_idx;
  logic [31:0] p_acc, p_body_size, p_body_rcvd;

  hrhp_pkg::in_item_t  pending_bytes[$];
  hrhp_pkg::out_item_t expected_results[$];
  int mismatches = 0;

  // Character set tests, written independently of the RTL package.
  function automatic bit chk_digit(logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic bit chk_ctl(logic [7:0] b);
    return b <= 8'd31 || b == 8'd127;
  endfunction

  function automatic bit chk_token(logic [7:0] b);
    string seps;
    seps = "()<>@,;:\\\"/[]?={} ";
    if (b[7] || chk_ctl(b)) return 0;
    for (int i = 0; i < seps.len(); i++)
      if (seps[i] == b) return 0;
    return 1;
  endfunction

  function automatic logic [7:0] cl_char(logic [3:0] i);
    string s;
    s = "Content-Length";
    return s[i];
  endfunction

  function automatic logic [15:0] ver_step(logic [15:0] acc, logic [7:0] b);
    logic [3:0] d;
    d = b[3:0];
    if (acc > (VER_MAX - d) / 10) return VER_MAX;
    return 16'(acc * 10 + d);
  endfunction

  function automatic logic [31:0] len_step(logic [31:0] acc, logic [7:0] b);
    logic [3:0] d;
    d = b[3:0];
    if (acc > (LEN_MAX - d) / 10) return LEN_MAX;
    return 32'(acc * 10 + d);
  endfunction

  task automatic clear_parser();
    p_phase = hrhp_pkg::PH_METHOD_START; p_status = hrhp_pkg::ST_INCOMPLETE;
    p_major = '0; p_minor = '0; p_seen_hdr = 0; p_idx = '0; p_still = 1;
    p_is_len = 0; p_acc = '0; p_ended = 0; p_exp_body = 0;
    p_body_size = '0; p_body_rcvd = '0;
  endtask

  task automatic match_name(logic [7:0] b);
    if (p_still && p_idx < hrhp_pkg::NAME_LEN && b == cl_char(p_idx)) p_idx++;
    else p_still = 0;
  endtask

  task automatic take_value(logic [7:0] b);
    if (p_is_len && !p_ended) begin
      if (chk_digit(b)) p_acc = len_step(p_acc, b);
      else p_ended = 1;
    end
  endtask

  // Advances the parser by one byte and queues the result it produces.
  task automatic parse_byte(hrhp_pkg::in_item_t it);
    logic [7:0] b;
    logic [2:0] cls;
    bit hb, bad, good;
    hrhp_pkg::out_item_t r;
    b = it.data_byte; cls = hrhp_pkg::CL_DELIM; hb = 0; bad = 0; good = 0;
    if (it.start_of_request) clear_parser();
    if (p_status == hrhp_pkg::ST_INCOMPLETE) begin
      case (p_phase)
        hrhp_pkg::PH_METHOD_START:
          if (chk_token(b)) begin
            p_phase = hrhp_pkg::PH_METHOD; cls = hrhp_pkg::CL_METHOD;
          end else bad = 1;
        hrhp_pkg::PH_METHOD:
          if (b == " ") p_phase = hrhp_pkg::PH_URI;
          else if (chk_token(b)) cls = hrhp_pkg::CL_METHOD;
          else bad = 1;
        hrhp_pkg::PH_URI:
          if (b == " ") p_phase = hrhp_pkg::PH_VER_H;
          else if (chk_ctl(b)) bad = 1;
          else cls = hrhp_pkg::CL_URI;
        hrhp_pkg::PH_VER_H:  if (b == "H") p_phase = hrhp_pkg::PH_VER_T1; else bad = 1;
        hrhp_pkg::PH_VER_T1: if (b == "T") p_phase = hrhp_pkg::PH_VER_T2; else bad = 1;
        hrhp_pkg::PH_VER_T2: if (b == "T") p_phase = hrhp_pkg::PH_VER_P; else bad = 1;
        hrhp_pkg::PH_VER_P:  if (b == "P") p_phase = hrhp_pkg::PH_VER_SLASH; else bad = 1;
        hrhp_pkg::PH_VER_SLASH:
          if (b == "/") begin
            p_major = '0; p_minor = '0; p_phase = hrhp_pkg::PH_MAJOR_START;
          end else bad = 1;
        hrhp_pkg::PH_MAJOR_START, hrhp_pkg::PH_MAJOR:
          if (chk_digit(b)) begin
            p_major = ver_step(p_major, b); p_phase = hrhp_pkg::PH_MAJOR;
          end else if (b == "." && p_phase == hrhp_pkg::PH_MAJOR)
            p_phase = hrhp_pkg::PH_MINOR_START;
          else bad = 1;
        hrhp_pkg::PH_MINOR_START, hrhp_pkg::PH_MINOR:
          if (chk_digit(b)) begin
            p_minor = ver_step(p_minor, b); p_phase = hrhp_pkg::PH_MINOR;
          end else if (b == 8'h0D && p_phase == hrhp_pkg::PH_MINOR)
            p_phase = hrhp_pkg::PH_NL1;
          else bad = 1;
        hrhp_pkg::PH_NL1: if (b == 8'h0A) p_phase = hrhp_pkg::PH_LINE_START; else bad = 1;
        hrhp_pkg::PH_LINE_START:
          if (b == 8'h0D) p_phase = hrhp_pkg::PH_NL3;
          else if (p_seen_hdr && (b == " " || b == 8'h09)) p_phase = hrhp_pkg::PH_LWS;
          else if (chk_token(b)) begin
            p_seen_hdr = 1; p_idx = '0; p_still = 1; p_is_len = 0;
            p_acc = '0; p_ended = 0;
            match_name(b);
            p_phase = hrhp_pkg::PH_NAME; cls = hrhp_pkg::CL_NAME; hb = 1;
          end else bad = 1;
        hrhp_pkg::PH_LWS:
          if (b == 8'h0D) p_phase = hrhp_pkg::PH_NL2;
          else if (b == " " || b == 8'h09) ;
          else if (chk_ctl(b)) bad = 1;
          else begin
            p_phase = hrhp_pkg::PH_VALUE; take_value(b); cls = hrhp_pkg::CL_VALUE;
          end
        hrhp_pkg::PH_NAME:
          if (b == ":") begin
            p_is_len = p_still && p_idx == hrhp_pkg::NAME_LEN;
            if (p_is_len) p_exp_body = 1;
            p_phase = hrhp_pkg::PH_SPACE;
          end else if (chk_token(b)) begin
            match_name(b); cls = hrhp_pkg::CL_NAME;
          end else bad = 1;
        hrhp_pkg::PH_SPACE: if (b == " ") p_phase = hrhp_pkg::PH_VALUE; else bad = 1;
        hrhp_pkg::PH_VALUE:
          if (b == 8'h0D) begin
            if (p_is_len) p_body_size = p_acc;
            p_phase = hrhp_pkg::PH_NL2;
          end else if (chk_ctl(b)) bad = 1;
          else begin take_value(b); cls = hrhp_pkg::CL_VALUE; end
        hrhp_pkg::PH_NL2: if (b == 8'h0A) p_phase = hrhp_pkg::PH_LINE_START; else bad = 1;
        hrhp_pkg::PH_NL3:
          if (b == 8'h0A) begin
            if (p_exp_body && p_body_size != 0) begin
              p_body_rcvd = '0; p_phase = hrhp_pkg::PH_BODY;
            end else good = 1;
          end else bad = 1;
        hrhp_pkg::PH_BODY: begin
          cls = hrhp_pkg::CL_BODY;
          p_body_rcvd++;
          if (p_body_rcvd >= p_body_size) good = 1;
        end
        default: bad = 1;
      endcase
      if (bad) begin p_status = hrhp_pkg::ST_MALFORMED; cls = hrhp_pkg::CL_DELIM; hb = 0; end
      else if (good) p_status = hrhp_pkg::ST_COMPLETE;
    end
    r.parse_status = p_status; r.byte_class = cls; r.header_begins = hb;
    r.byte_out = b; r.major_version = p_major; r.minor_version = p_minor;
    r.body_length = p_body_size; r.body_expected = p_exp_body;
    expected_results = {expected_results, r};
  endtask

  // Stimulus building.
  task automatic push_str(string s, bit first);
    hrhp_pkg::in_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.data_byte = s[i];
      it.start_of_request = first && i == 0;
      pending_bytes = {pending_bytes, it};
    end
  endtask

  task automatic push_raw(logic [7:0] b, bit sor);
    hrhp_pkg::in_item_t it;
    it.data_byte = b; it.start_of_request = sor;
    pending_bytes = {pending_bytes, it};
  endtask

  function automatic string rand_token(int n);
    string s, pool;
    pool = "abcXYZ09!#$%&'*+-.^_`|~";
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(pool[$urandom_range(pool.len()-1)])};
    return s;
  endfunction

  function automatic string rand_uri(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(32, 255) == 127 ?
      8'h41 : $urandom_range(33, 255)))};
    return s;
  endfunction

  // One well-formed request with random content, sometimes with a fault.
  task automatic push_request();
    string s, crlf;
    int blen;
    crlf = "\r\n";
    blen = $urandom_range(0, 6);
    s = {rand_token($urandom_range(1, 4)), " ", rand_uri($urandom_range(0, 4)),
         " HTTP/", $sformatf("%0d.%0d", $urandom_range(0, 12), $urandom_range(0, 99)),
         crlf};
    if ($urandom_range(1)) s = {s, rand_token($urandom_range(1, 5)), ": ",
                                rand_uri($urandom_range(0, 3)), crlf};
    if ($urandom_range(3) != 0) begin
      s = {s, "Content-Length: ", $sformatf("%0d", blen)};
      if ($urandom_range(3) == 0) s = {s, crlf, "\t", $sformatf("%0d", $urandom_range(9))};
      else if ($urandom_range(3) == 0) s = {s, "x7"};
      s = {s, crlf};
    end else if ($urandom_range(2) == 0) begin
      s = {s, "Content-Lengtx: 3", crlf};
    end
    s = {s, crlf};
    push_str(s, 1);
    for (int i = 0; i < blen + $urandom_range(0, 2); i++)
      push_raw(8'($urandom_range(0, 255)), 0);
    // Occasional corruption of a random byte of the last request.
    if ($urandom_range(4) == 0) begin
      int k;
      k = pending_bytes.size() - 1 - $urandom_range(0, s.len() - 2);
      pending_bytes[k].data_byte = 8'($urandom_range(0, 255));
    end
  endtask

  // Handshake sampled at the rising edge, used by the driver afterwards.
  logic in_stall_q = 1'b0;
  always @(posedge clk) begin
    in_stall_q <= in_stall;
    if (!rst && in_valid && !in_stall) parse_byte(in_data);
  end

  // Driver: offers queued items, with a random gap before each one.
  int in_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall_q) begin
        // The item was taken: draw the gap before the next one.
        in_gap = $urandom_range(0, 10);
        if ($urandom_range(3) == 0) in_gap = 0;
        if (in_gap == 0 && pending_bytes.size() > 0) begin
          in_data <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!in_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_bytes.size() > 0) begin
          in_data <= pending_bytes.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Receiver stall: a random number of stalled cycles before each item.
  int out_hold = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (out_hold > 0) begin
        out_hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      hrhp_pkg::out_item_t e;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %p", out_data);
      end else begin
        e = expected_results.pop_front();
        if (out_data !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", e, out_data);
        end
      end
      out_hold = ($urandom_range(2) == 0) ? 0 : $urandom_range(0, 10);
    end
  end

  initial begin
    clear_parser();
    // Directed: plain request, zero length, body, folding, saturation, faults.
    push_str("GET /a HTTP/1.1\r\nHost: x\r\n\r\n", 1);
    push_str("POST / HTTP/99999.70000\r\nContent-Length: 0\r\n\r\n", 1);
    push_str("PUT /\xff HTTP/1.0\r\nContent-Length: 3\r\n\t 2\r\n\r\n", 1);
    push_raw(8'h00, 0); push_raw(8'hFF, 0);
    for (int i = 0; i < 30; i++) push_raw(i[7:0], 0);
    push_str("X / HTTP/1.1\r\nContent-Length: 99999999999\r\n\r\nzz", 1);
    push_str(" GET", 1);
    push_str("G / HTTP/1.1\r\n x\r\n", 1);
    push_str("G / HTTP/.1\r\n", 1);
    push_str("G / HTTP/1.\r\n", 1);
    push_str("G / HTTP/1.1\r\nA:B\r\n", 1);
    push_str("G / HTTP/1.1\r\nA: b\rx", 1);
    push_str("G / HTTPx", 1);
    push_str("G\x7f", 1);
    // Random bytes touch every bit of the byte and the start flag.
    for (int i = 0; i < 40; i++)
      push_raw(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    while (pending_bytes.size() < 590) push_request();
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    wait (pending_bytes.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
